[hdl/mapg_pkg.sv]
// ============================================================================
// mapg_pkg: shared types and constants for the masked adaptive pixel gain
// Holds the register map, the status codes, the channel and arithmetic widths
// and the constants for the percent scaling that the pipeline modules share.
// ============================================================================
package mapg_pkg;

    localparam int NUM_CH      = 3;
    localparam int CH_W        = 8;
    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int AMP_W       = 10;
    localparam int COUNT_W     = 5;
    localparam int SLOT_W      = 4;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 13;

    localparam int MAX_RECTS_DEFAULT = 16;
    localparam int MAX_WIDTH         = 4096;

    localparam int EDGE_MARGIN = 5;
    localparam int FULL_SCALE  = 255;
    localparam int PERCENT     = 100;

    // Gain is 100 plus up to 1023, so it needs 11 bits.
    localparam int GAIN_W = 11;
    localparam int PROD_W = CH_W + GAIN_W;

    // A scaled value overflows when value * gain reaches this bound.
    localparam int OVF_LIMIT = (FULL_SCALE + 1) * PERCENT;
    localparam int SEL_W     = $clog2(OVF_LIMIT);

    // floor(p / 100) == (p * 5243) >> 19 for every p below the overflow bound.
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + PERCENT - 1) / PERCENT;
    localparam int RECIP_W     = SEL_W + 13;

    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_AMPLIFY      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_ROW    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LAST_ROW     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECT_COUNT   = 3'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        ST_SKIP = 2'd0,
        ST_OVF  = 2'd1,
        ST_FULL = 2'd2,
        ST_HALF = 2'd3
    } mapg_status_t;

    // Load enables of the pipeline stages.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } mapg_adv_t;

    // Settings derived from the configuration registers.
    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [GAIN_W-1:0]  half_gain;
        logic [COORD_W-1:0] first_row;
        logic [DIM_W-1:0]   row_end;
        logic [DIM_W-1:0]   width_sat;
    } mapg_cfg_t;

endpackage

[hdl/masked_adaptive_pixel_gain.sv]
// ============================================================================
// masked_adaptive_pixel_gain: windowed, rectangle-masked pixel gain
// Top level: configuration registers, input stage, stage valid chain and the
// rectangle and scaling datapaths.
// ============================================================================
// The block takes one transaction per clock cycle while s_ready is high. A pixel
// transaction passes four register stages (input capture, rectangle compare and
// channel multiplies, overflow decision, reciprocal divide by 100), and the first
// of them loads at the accepting edge. Each stage takes a new item every cycle
// while its successor moves or is empty, so a stalled result holds only the
// stages behind it. A load transaction writes its rectangle slot at the accepting
// edge, is seen by every later pixel, and gives no result. The rectangle store is
// not cleared after reset; a slot must be loaded before rect_count makes it
// active. Configuration must be written only while no pixel is in flight; the
// block itself does not enforce this.
module masked_adaptive_pixel_gain
    import mapg_pkg::*;
#(
    parameter int MAX_RECTS = MAX_RECTS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [COORD_W-1:0]    s_pixel_x,
    input  logic [COORD_W-1:0]    s_pixel_y,
    input  logic [NUM_CH-1:0]     s_src_nonzero_mask,
    input  logic [CH_W-1:0]       s_cur_chan0,
    input  logic [CH_W-1:0]       s_cur_chan1,
    input  logic [CH_W-1:0]       s_cur_chan2,
    input  logic [SLOT_W-1:0]     s_rect_slot,
    input  logic [COORD_W-1:0]    s_rect_left,
    input  logic [COORD_W-1:0]    s_rect_top,
    input  logic [COORD_W-1:0]    s_rect_right,
    input  logic [COORD_W-1:0]    s_rect_bottom,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [CH_W-1:0]       m_out_chan0,
    output logic [CH_W-1:0]       m_out_chan1,
    output logic [CH_W-1:0]       m_out_chan2
);

    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;
    logic [AMP_W-1:0]     amp_reg;
    logic [COORD_W-1:0]   first_row_reg;
    logic [DIM_W-1:0]     last_row_reg;
    logic [COUNT_W-1:0]   rect_count_reg;

    mapg_cfg_t            cfg;
    logic [MAX_RECTS-1:0] active;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 ready1, ready2, ready3, ready4;
    mapg_adv_t            adv;

    logic [COORD_W-1:0]   x1_reg;
    logic [COORD_W-1:0]   y1_reg;
    logic [NUM_CH-1:0]    mask1_reg;
    logic [CH_W-1:0]      ch1_reg [NUM_CH];

    logic                 accept;
    logic                 load_wr;
    logic                 hit_any;
    mapg_status_t         status;
    logic [CH_W-1:0]      out_ch [NUM_CH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= DIM_W'(640);
            height_reg     <= DIM_W'(480);
            amp_reg        <= '0;
            first_row_reg  <= '0;
            last_row_reg   <= '0;
            rect_count_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IMAGE_WIDTH:  width_reg      <= cfg_wdata;
                CFG_IMAGE_HEIGHT: height_reg     <= cfg_wdata;
                CFG_AMPLIFY:      amp_reg        <= cfg_wdata[AMP_W-1:0];
                CFG_FIRST_ROW:    first_row_reg  <= cfg_wdata[COORD_W-1:0];
                CFG_LAST_ROW:     last_row_reg   <= cfg_wdata;
                CFG_RECT_COUNT:   rect_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.gain      = GAIN_W'(PERCENT) + GAIN_W'(amp_reg);
        cfg.half_gain = cfg.gain >> 1;
        cfg.first_row = first_row_reg;
        cfg.row_end   = (last_row_reg == '0) ? height_reg : last_row_reg;
        cfg.width_sat = (32'(width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_reg;
        // Slots beyond the store depth never exist, so the count saturates here.
        for (int i = 0; i < MAX_RECTS; i++) begin
            active[i] = 32'(i) < 32'(rect_count_reg);
        end
    end

    // Each stage loads when it is empty or its content moves on.
    assign ready4  = !v4_reg || m_ready;
    assign ready3  = !v3_reg || ready4;
    assign ready2  = !v2_reg || ready3;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = ready1;
    assign adv.s2  = ready2;
    assign adv.s3  = ready3;
    assign adv.s4  = ready4;

    assign accept  = s_valid && s_ready;
    assign load_wr = accept && (s_op == OP_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_valid && (s_op == OP_PIXEL);
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
            if (ready4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1) begin
            x1_reg     <= s_pixel_x;
            y1_reg     <= s_pixel_y;
            mask1_reg  <= s_src_nonzero_mask;
            ch1_reg[0] <= s_cur_chan0;
            ch1_reg[1] <= s_cur_chan1;
            ch1_reg[2] <= s_cur_chan2;
        end
    end

    mapg_rect_match #(
        .MAX_RECTS (MAX_RECTS)
    ) u_rect_match (
        .aclk      (aclk),
        .wr_en     (load_wr),
        .wr_slot   (s_rect_slot),
        .wr_left   (s_rect_left),
        .wr_top    (s_rect_top),
        .wr_right  (s_rect_right),
        .wr_bottom (s_rect_bottom),
        .adv       (adv),
        .pix_x     (x1_reg),
        .pix_y     (y1_reg),
        .active    (active),
        .hit_any   (hit_any)
    );

    mapg_scale u_scale (
        .aclk     (aclk),
        .adv      (adv),
        .cfg      (cfg),
        .pix_x    (x1_reg),
        .pix_y    (y1_reg),
        .pix_mask (mask1_reg),
        .pix_ch   (ch1_reg),
        .hit_any  (hit_any),
        .status   (status),
        .out_ch   (out_ch)
    );

    assign m_valid     = v4_reg;
    assign m_status    = status;
    assign m_out_chan0 = out_ch[0];
    assign m_out_chan1 = out_ch[1];
    assign m_out_chan2 = out_ch[2];

    // An accepted pixel always occupies the input stage on the next cycle.
    a_pixel_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_op == OP_PIXEL)) |=> v1_reg)
        else $error("accepted pixel did not enter the pipeline");

    // A load transaction never creates a result slot.
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_op == OP_LOAD)) |=> !v1_reg)
        else $error("load transaction entered the pixel pipeline");

    // An empty pipeline always takes a transaction.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v1_reg && !v2_reg && !v3_reg && !v4_reg) |-> s_ready)
        else $error("empty pipeline refused input");

    // A result held by the output stage keeps the middle stages from advancing
    // only when they are full.
    a_stall_holds_s3: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !m_ready && v3_reg) |=> v3_reg && v4_reg)
        else $error("stalled pipeline lost a stage");

endmodule

[hdl/mapg_rect_match.sv]
// ============================================================================
// mapg_rect_match: exclusion rectangle store and containment compare
// Keeps the rectangle slots in registers, compares one pixel position against
// every active slot in parallel and registers one hit bit per slot.
// ============================================================================
module mapg_rect_match
    import mapg_pkg::*;
#(
    parameter int MAX_RECTS = MAX_RECTS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [SLOT_W-1:0]    wr_slot,
    input  logic [COORD_W-1:0]   wr_left,
    input  logic [COORD_W-1:0]   wr_top,
    input  logic [COORD_W-1:0]   wr_right,
    input  logic [COORD_W-1:0]   wr_bottom,
    input  mapg_adv_t            adv,
    input  logic [COORD_W-1:0]   pix_x,
    input  logic [COORD_W-1:0]   pix_y,
    input  logic [MAX_RECTS-1:0] active,
    output logic                 hit_any
);

    logic [COORD_W-1:0]   left_reg   [MAX_RECTS];
    logic [COORD_W-1:0]   top_reg    [MAX_RECTS];
    logic [COORD_W-1:0]   right_reg  [MAX_RECTS];
    logic [COORD_W-1:0]   bottom_reg [MAX_RECTS];
    logic [MAX_RECTS-1:0] hit_reg;
    logic [MAX_RECTS-1:0] hit_next;

    // A slot at or beyond the store depth simply matches no entry.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RECTS; i++) begin
            if (wr_en && (32'(wr_slot) == 32'(i))) begin
                left_reg[i]   <= wr_left;
                top_reg[i]    <= wr_top;
                right_reg[i]  <= wr_right;
                bottom_reg[i] <= wr_bottom;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_RECTS; i++) begin
            hit_next[i] = active[i]
                && (pix_x >= left_reg[i]) && (pix_x <= right_reg[i])
                && (pix_y >= top_reg[i])  && (pix_y <= bottom_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            hit_reg <= hit_next;
        end
    end

    assign hit_any = |hit_reg;

endmodule

[hdl/mapg_scale.sv]
// ============================================================================
// mapg_scale: window test and percent gain datapath
// Three register stages: channel products at full and halved gain, overflow
// decision and product select, then the divide by 100 as a reciprocal multiply.
// ============================================================================
module mapg_scale
    import mapg_pkg::*;
(
    input  logic               aclk,
    input  mapg_adv_t          adv,
    input  mapg_cfg_t          cfg,
    input  logic [COORD_W-1:0] pix_x,
    input  logic [COORD_W-1:0] pix_y,
    input  logic [NUM_CH-1:0]  pix_mask,
    input  logic [CH_W-1:0]    pix_ch [NUM_CH],
    input  logic               hit_any,
    output mapg_status_t       status,
    output logic [CH_W-1:0]    out_ch [NUM_CH]
);

    // Stage 2
    logic               win_ok_reg;
    logic [NUM_CH-1:0]  mask2_reg;
    logic [CH_W-1:0]    ch2_reg    [NUM_CH];
    logic [PROD_W-1:0]  pfull2_reg [NUM_CH];
    logic [PROD_W-1:0]  phalf2_reg [NUM_CH];
    logic               win_ok_next;

    // Stage 3
    mapg_status_t       status3_reg;
    mapg_status_t       status3_next;
    logic [NUM_CH-1:0]  mask3_reg;
    logic [CH_W-1:0]    ch3_reg    [NUM_CH];
    logic [SEL_W-1:0]   psel3_reg  [NUM_CH];
    logic [SEL_W-1:0]   psel3_next [NUM_CH];
    logic               over_full;
    logic               over_half;

    // Stage 4
    mapg_status_t       status4_reg;
    logic [CH_W-1:0]    out4_reg   [NUM_CH];
    logic [CH_W-1:0]    out4_next  [NUM_CH];
    logic [RECIP_W-1:0] recip      [NUM_CH];
    logic               scaled3;

    assign win_ok_next = (pix_y >= cfg.first_row)
        && ({1'b0, pix_y} < cfg.row_end)
        && (pix_x >= COORD_W'(EDGE_MARGIN))
        && (({1'b0, pix_x} + DIM_W'(EDGE_MARGIN)) < cfg.width_sat);

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            win_ok_reg <= win_ok_next;
            mask2_reg  <= pix_mask;
            for (int c = 0; c < NUM_CH; c++) begin
                ch2_reg[c]    <= pix_ch[c];
                pfull2_reg[c] <= PROD_W'(pix_ch[c]) * PROD_W'(cfg.gain);
                phalf2_reg[c] <= PROD_W'(pix_ch[c]) * PROD_W'(cfg.half_gain);
            end
        end
    end

    always_comb begin
        over_full = 1'b0;
        over_half = 1'b0;
        for (int c = 0; c < NUM_CH; c++) begin
            if (mask2_reg[c] && (pfull2_reg[c] >= PROD_W'(OVF_LIMIT))) begin
                over_full = 1'b1;
            end
            if (mask2_reg[c] && (phalf2_reg[c] >= PROD_W'(OVF_LIMIT))) begin
                over_half = 1'b1;
            end
        end
        if (!win_ok_reg || hit_any) begin
            status3_next = ST_SKIP;
        end else if (!over_full) begin
            status3_next = ST_FULL;
        end else if (!over_half) begin
            status3_next = ST_HALF;
        end else begin
            status3_next = ST_OVF;
        end
        // The selected product is only used when it is below the overflow bound.
        for (int c = 0; c < NUM_CH; c++) begin
            psel3_next[c] = over_full ? phalf2_reg[c][SEL_W-1:0]
                                      : pfull2_reg[c][SEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            status3_reg <= status3_next;
            mask3_reg   <= mask2_reg;
            for (int c = 0; c < NUM_CH; c++) begin
                ch3_reg[c]   <= ch2_reg[c];
                psel3_reg[c] <= psel3_next[c];
            end
        end
    end

    assign scaled3 = (status3_reg == ST_FULL) || (status3_reg == ST_HALF);

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            recip[c] = RECIP_W'(psel3_reg[c]) * RECIP_W'(RECIP_MUL);
            out4_next[c] = (scaled3 && mask3_reg[c]) ? recip[c][RECIP_SHIFT +: CH_W]
                                                     : ch3_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s4) begin
            status4_reg <= status3_reg;
            for (int c = 0; c < NUM_CH; c++) begin
                out4_reg[c] <= out4_next[c];
            end
        end
    end

    assign status = status4_reg;
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            out_ch[c] = out4_reg[c];
        end
    end

endmodule
